FILE: src/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/shm_pkg.sv
// Package for the session heartbeat monitor: sizes, codes and entry types.
// No dependencies.
`default_nettype none

package shm_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int ID_W          = 8;
   localparam int TMO_W         = 32;

   localparam logic [TMO_W-1:0] COUNT_MAX = '1;

   // operations
   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_ADD       = 3'd1;
   localparam logic [2:0] OP_REMOVE    = 3'd2;
   localparam logic [2:0] OP_KEEPALIVE = 3'd3;
   localparam logic [2:0] OP_SET_TMO   = 3'd4;
   localparam logic [2:0] OP_QUERY     = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_HEARTBEAT = 2'd0;
   localparam logic [1:0] KIND_CLOSE     = 2'd1;
   localparam logic [1:0] KIND_REPLY     = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_IGNORED  = 2'd1;
   localparam logic [1:0] ST_DISABLED = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // cell commands
   localparam logic [2:0] CMD_HOLD      = 3'd0;
   localparam logic [2:0] CMD_ROTATE    = 3'd1;
   localparam logic [2:0] CMD_INSERT    = 3'd2;
   localparam logic [2:0] CMD_REMOVE    = 3'd3;
   localparam logic [2:0] CMD_KEEPALIVE = 3'd4;
   localparam logic [2:0] CMD_SET_TMO   = 3'd5;

   // register map
   localparam logic [1:0] ADDR_DEFAULT_TMO = 2'd0;

   typedef struct packed {
      logic             valid;
      logic [ID_W-1:0]  session;
      logic [TMO_W-1:0] timeout;
      logic [TMO_W-1:0] elapsed;
      logic             hb_sent;
   } entry_type;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [ID_W-1:0]  key;
      logic [TMO_W-1:0] tmo;
   } cell_ctrl_type;

   localparam entry_type EMPTY_ENTRY = '0;

endpackage

`default_nettype wire

FILE: src/shm_cell.sv
// One table cell: holds one session entry and trades it with its neighbors.
// Depends on shm_pkg.
`default_nettype none

module shm_cell import shm_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     left_entry,
   input  wire entry_type     right_entry,
   input  wire entry_type     ret_entry,
   input  wire                gt_left,
   output entry_type          entry,
   output logic               gt_out,
   output logic               match_out
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      ge;

   always_comb begin
      match_out = entry_ff.valid && (entry_ff.session == ctrl.key);
      gt_out    = !entry_ff.valid || (entry_ff.session > ctrl.key);
      ge        = entry_ff.valid && (entry_ff.session >= ctrl.key);
   end

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.cmd)
         CMD_HOLD: begin
         end
         CMD_ROTATE: begin
            // pull from the right; the last occupied cell takes the returned head
            if (right_entry.valid) begin
               entry_in = right_entry;
            end else if (entry_ff.valid) begin
               entry_in = ret_entry;
            end
         end
         CMD_INSERT: begin
            if (gt_left) begin
               entry_in = left_entry;
            end else if (gt_out) begin
               entry_in.valid   = 1'b1;
               entry_in.session = ctrl.key;
               entry_in.timeout = ctrl.tmo;
               entry_in.elapsed = '0;
               entry_in.hb_sent = 1'b0;
            end
         end
         CMD_REMOVE: begin
            if (ge) begin
               entry_in = right_entry;
            end
         end
         CMD_KEEPALIVE: begin
            if (match_out) begin
               entry_in.hb_sent = 1'b0;
               entry_in.elapsed = '0;
            end
         end
         CMD_SET_TMO: begin
            if (match_out) begin
               entry_in.timeout = ctrl.tmo;
               entry_in.elapsed = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

FILE: src/shm_tick_unit.sv
// Head unit: advances one entry by a millisecond and decides heartbeat or close.
// Depends on shm_pkg.
`default_nettype none

module shm_tick_unit import shm_pkg::*; (
   input  wire entry_type head,
   output entry_type      ret,
   output logic           expired,
   output logic           close
);

   logic [TMO_W-1:0] count;

   always_comb begin
      count   = (head.elapsed == COUNT_MAX) ? head.elapsed : head.elapsed + TMO_W'(1);
      expired = count > head.timeout;
      close   = expired && head.hb_sent;
      ret     = head;
      if (!expired) begin
         ret.elapsed = count;
      end else if (close) begin
         ret.valid = 1'b0;
      end else begin
         ret.hb_sent = 1'b1;
         ret.elapsed = '0;
      end
   end

endmodule

`default_nettype wire

FILE: src/session_heartbeat_monitor.sv
// Session heartbeat monitor: non-tick operations reply in the cycle after start and busy stays low.
// A tick on a non-empty table keeps busy high while the row of cells rotates one entry per cycle
// past the single head unit, once for each session in the table, and then while it flushes.
// Tick results come out at most one per cycle in ascending id order; the receiver cannot stall.
// Synchronous reset empties the table, clears the default timeout and returns to idle.
`default_nettype none

module session_heartbeat_monitor import shm_pkg::*; (
   input  wire              clock,
   input  wire              reset,
   // command channel
   input  wire              start,
   output logic             busy,
   input  wire  [2:0]       req_operation,
   input  wire  [ID_W-1:0]  req_session_id,
   input  wire  [TMO_W-1:0] req_timeout_ms,
   // result channel
   output logic             rsp_strobe,
   output logic [1:0]       rsp_kind,
   output logic [ID_W-1:0]  rsp_session_id_out,
   output logic [1:0]       rsp_status,
   output logic             rsp_tracked,
   output logic             rsp_last,
   // configuration port
   input  wire              psel,
   input  wire              penable,
   input  wire              pwrite,
   input  wire  [1:0]       paddr,
   input  wire  [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_TICK  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;       // occupied cells, packed at the front
   logic [CNT_W-1:0] left_ff, left_in;     // entries still to pass the head this tick
   logic             pend_valid_ff, pend_valid_in;
   logic [1:0]       pend_kind_ff, pend_kind_in;
   logic [ID_W-1:0]  pend_id_ff, pend_id_in;
   logic [TMO_W-1:0] dflt_tmo_ff;

   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_tracked_ff, rsp_tracked_in;
   logic             rsp_last_ff, rsp_last_in;

   cell_ctrl_type      ctrl;
   entry_type          cell_q [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] gt_vec;
   logic [TABLE_ENTRIES-1:0] match_vec;
   entry_type          ret_entry;
   logic               tick_expired;
   logic               tick_close;
   logic               found;

   // ---------------------------------------------------------------------------
   // Configuration port: one register, always ready.
   // ---------------------------------------------------------------------------
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_DEFAULT_TMO) ? dflt_tmo_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_tmo_ff <= '0;
      end else if (psel && penable && pwrite && (paddr == ADDR_DEFAULT_TMO)) begin
         dflt_tmo_ff <= pwdata;
      end
   end

   // ---------------------------------------------------------------------------
   // Row of cells. Valid entries sit packed at the front in ascending id order,
   // so insert and remove are a single shift right or left from the match
   // point, and a rotation presents entries to the head in id order.
   // ---------------------------------------------------------------------------
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      shm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  ((i == 0) ? EMPTY_ENTRY : cell_q[(i == 0) ? 0 : i - 1]),
         .right_entry ((i == TABLE_ENTRIES - 1) ? EMPTY_ENTRY
                                                : cell_q[(i == TABLE_ENTRIES - 1) ? i : i + 1]),
         .ret_entry   (ret_entry),
         .gt_left     ((i == 0) ? 1'b0 : gt_vec[(i == 0) ? 0 : i - 1]),
         .entry       (cell_q[i]),
         .gt_out      (gt_vec[i]),
         .match_out   (match_vec[i])
      );
   end

   assign found = |match_vec;

   // Head unit works on whatever sits in the first cell during a tick.
   shm_tick_unit u_tick (
      .head    (cell_q[0]),
      .ret     (ret_entry),
      .expired (tick_expired),
      .close   (tick_close)
   );

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      ctrl.cmd       = CMD_HOLD;
      ctrl.key       = req_session_id;
      ctrl.tmo       = req_timeout_ms;
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      left_in        = left_ff;
      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_id_in     = pend_id_ff;
      rsp_strobe_in  = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_tracked_in = rsp_tracked_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               // every non-tick transaction answers with exactly one reply
               rsp_strobe_in  = 1'b1;
               rsp_kind_in    = KIND_REPLY;
               rsp_id_in      = req_session_id;
               rsp_status_in  = ST_IGNORED;
               rsp_tracked_in = 1'b0;
               rsp_last_in    = 1'b1;
               unique case (req_operation)
                  OP_TICK: begin
                     rsp_strobe_in = 1'b0;
                     pend_valid_in = 1'b0;
                     if (cnt_ff != '0) begin
                        state_in = S_TICK;
                        left_in  = cnt_ff;
                     end
                  end
                  OP_ADD: begin
                     // disabled beats duplicate, duplicate beats full
                     if (dflt_tmo_ff == '0) begin
                        rsp_status_in = ST_DISABLED;
                     end else if (found) begin
                        rsp_status_in = ST_IGNORED;
                     end else if (cnt_ff == CNT_FULL) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_DONE;
                        ctrl.cmd      = CMD_INSERT;
                        ctrl.tmo      = dflt_tmo_ff;
                        cnt_in        = cnt_ff + CNT_ONE;
                     end
                  end
                  OP_REMOVE: begin
                     if (found) begin
                        rsp_status_in = ST_DONE;
                        ctrl.cmd      = CMD_REMOVE;
                        cnt_in        = cnt_ff - CNT_ONE;
                     end
                  end
                  OP_KEEPALIVE: begin
                     if (found) begin
                        rsp_status_in = ST_DONE;
                        ctrl.cmd      = CMD_KEEPALIVE;
                     end
                  end
                  OP_SET_TMO: begin
                     if (found) begin
                        rsp_status_in = ST_DONE;
                        ctrl.cmd      = CMD_SET_TMO;
                     end
                  end
                  OP_QUERY: begin
                     rsp_status_in  = ST_DONE;
                     rsp_tracked_in = found;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_TICK: begin
            // advance the row by one; hold each result in the pending register until
            // the next one or the flush, so the final one can carry the last flag
            ctrl.cmd = CMD_ROTATE;
            if (tick_expired) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_kind_in    = pend_kind_ff;
                  rsp_id_in      = pend_id_ff;
                  rsp_status_in  = ST_DONE;
                  rsp_tracked_in = 1'b0;
                  rsp_last_in    = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_kind_in  = tick_close ? KIND_CLOSE : KIND_HEARTBEAT;
               pend_id_in    = cell_q[0].session;
               if (tick_close) begin
                  cnt_in = cnt_ff - CNT_ONE;
               end
            end
            left_in = left_ff - CNT_ONE;
            if (left_ff == CNT_ONE) begin
               state_in = S_FLUSH;
            end
         end

         S_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_strobe_in  = 1'b1;
               rsp_kind_in    = pend_kind_ff;
               rsp_id_in      = pend_id_ff;
               rsp_status_in  = ST_DONE;
               rsp_tracked_in = 1'b0;
               rsp_last_in    = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         left_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         left_ff       <= left_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      pend_kind_ff   <= pend_kind_in;
      pend_id_ff     <= pend_id_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tracked_ff <= rsp_tracked_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_session_id_out = rsp_id_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_tracked        = rsp_tracked_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

FILE: src/shm_checker.sv
// Port-level checker for the session heartbeat monitor, bound to the top level.
// Depends on shm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module shm_checker import shm_pkg::*; (
   input wire             clock,
   input wire             reset,
   input wire             start,
   input wire             busy,
   input wire [2:0]       req_operation,
   input wire             rsp_strobe,
   input wire [1:0]       rsp_kind,
   input wire [1:0]       rsp_status,
   input wire             rsp_tracked,
   input wire             rsp_last
);

   `SHM_ASSERT_NEXT(a_reply_follows, clock, reset, start && !busy && (req_operation != OP_TICK), rsp_strobe && (rsp_kind == KIND_REPLY) && rsp_last, "non-tick transaction gave no reply")
   `SHM_ASSERT_NEXT(a_tick_quiet_first, clock, reset, start && !busy && (req_operation == OP_TICK), !rsp_strobe, "result right after tick start")
   `SHM_ASSERT_IMPLY(a_tick_fields, clock, reset, rsp_strobe && (rsp_kind != KIND_REPLY), (rsp_status == ST_DONE) && !rsp_tracked && ((rsp_kind == KIND_HEARTBEAT) || (rsp_kind == KIND_CLOSE)), "bad tick result fields")
   `SHM_ASSERT_IMPLY(a_reply_idle, clock, reset, rsp_strobe && (rsp_kind == KIND_REPLY), !busy, "reply while busy")

endmodule

bind session_heartbeat_monitor shm_checker u_shm_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_operation (req_operation),
   .rsp_strobe    (rsp_strobe),
   .rsp_kind      (rsp_kind),
   .rsp_status    (rsp_status),
   .rsp_tracked   (rsp_tracked),
   .rsp_last      (rsp_last)
);

`default_nettype wire
